/* hw/rtl/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, sizes and index helpers for the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

  // ring storage size and derived widths
  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CAP_W = IDX_W + 1;
  localparam int LEN_W = 9;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 8;

  // ring length after reset
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

  typedef logic [IDX_W-1:0] brf_idx_t;
  typedef logic [CAP_W-1:0] brf_cap_t;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_SKIP = 2'd3
  } brf_cmd_t;

  typedef struct packed {
    brf_cmd_t          command;
    logic [BYTE_W-1:0] data_in;
    logic [CNT_W-1:0]  skip_count;
  } brf_in_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] data_out;
    logic [CNT_W-1:0]  skipped;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  linear_used;
  } brf_out_t;

  // write request toward the ring memory
  typedef struct packed {
    logic              en;
    brf_idx_t          addr;
    logic [BYTE_W-1:0] data;
  } brf_wr_t;

  // step an index by one, wrapping at the ring length
  function automatic brf_idx_t brf_advance(brf_idx_t idx, brf_cap_t cap);
    brf_cap_t n;
    n = {1'b0, idx} + CAP_W'(1);
    return (n >= cap) ? '0 : n[IDX_W-1:0];
  endfunction

  // bytes held between read and write index
  function automatic brf_cap_t brf_held(brf_idx_t wr, brf_idx_t rd, brf_cap_t cap);
    if (wr == rd) return '0;
    if (wr > rd) return {1'b0, wr} - {1'b0, rd};
    return {1'b0, wr} + cap - {1'b0, rd};
  endfunction

  // contiguous bytes from read index to write index or ring end
  function automatic brf_cap_t brf_held_lin(brf_idx_t wr, brf_idx_t rd, brf_cap_t cap);
    if (wr == rd) return '0;
    if (wr > rd) return {1'b0, wr} - {1'b0, rd};
    return cap - {1'b0, rd};
  endfunction

endpackage

/* hw/rtl/byte_ring_fifo.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte ring FIFO with configurable ring length: put, get, peek and skip.
// ----------------------------------------------------------------------------
//  channel  | ports                         | moves
//  ---------+-------------------------------+------------------------------
//  input    | in_valid, in_stall, in_data   | one command transaction
//  result   | out_valid, out_stall, out_data| one result per command
//  config   | cfg_we, cfg_wdata             | ring length write, empties fifo
//
// One transaction per cycle sustained while out_stall is low; a command
// passes through the input register, then the result register, and its
// result is valid once the result register holds it.
// The ring memory has a registered read, fed with the next head index, with a
// one-entry forward for a byte written at the head in the previous cycle.
// Reset is synchronous: indices clear and the ring length returns to 256.
// A stalled result holds the command in the input register; in_stall rises
// only while that register is full and cannot drain.
// ----------------------------------------------------------------------------
module byte_ring_fifo import brf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  brf_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output brf_out_t         out_data,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  logic              s_valid_r, s_valid_nxt;
  brf_in_t           s_item_r;
  logic              out_valid_r, out_valid_nxt;
  brf_out_t          out_data_r;
  logic              proc;
  logic              in_acc;
  brf_out_t          res;
  brf_idx_t          ram_raddr;
  brf_wr_t           ram_wr;
  logic [BYTE_W-1:0] ram_rdata;

  // handshake: the held command runs when the result register can take it
  assign proc     = s_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s_valid_r && !proc;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_acc) begin
      s_valid_nxt = 1'b1;
    end else if (proc) begin
      s_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (proc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_valid_r   <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_item_r <= in_data;
    end
    if (proc) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // index and command logic
  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .item      (s_item_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_rdata (ram_rdata),
    .ram_raddr (ram_raddr),
    .ram_wr    (ram_wr),
    .res       (res)
  );

  // ring storage
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* hw/rtl/brf_ram.sv */
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/brf_ctrl.sv */
// ----------------------------------------------------------------------------
// brf_ctrl
// Ring indices, ring length register and per-command result logic.
// ----------------------------------------------------------------------------
module brf_ctrl import brf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc,
  input  brf_in_t           item,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic [BYTE_W-1:0] ram_rdata,
  output brf_idx_t          ram_raddr,
  output brf_wr_t           ram_wr,
  output brf_out_t          res
);

  logic [LEN_W-1:0]  len_r;
  brf_idx_t          wr_r, wr_nxt;
  brf_idx_t          rd_r, rd_nxt;
  logic              byp_r, byp_nxt;
  logic [BYTE_W-1:0] byp_data_r;
  brf_cap_t          cap;
  brf_cap_t          lin_cur;
  brf_cap_t          used, lin, free;
  brf_idx_t          adv_wr;
  logic [CAP_W:0]    skip_sum;
  logic [BYTE_W-1:0] head_byte;

  // effective ring length, clamped to 2..DEPTH
  always_comb begin
    if (len_r < LEN_W'(2)) begin
      cap = CAP_W'(2);
    end else if ({{(32-LEN_W){1'b0}}, len_r} > DEPTH) begin
      cap = CAP_W'(DEPTH);
    end else begin
      cap = CAP_W'(len_r);
    end
  end

  // oldest byte, forwarded when it was written in the previous cycle
  assign head_byte = byp_r ? byp_data_r : ram_rdata;

  // command decode and index update
  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    ram_wr   = '0;
    res      = '0;
    lin_cur  = brf_held_lin(wr_r, rd_r, cap);
    adv_wr   = brf_advance(wr_r, cap);
    skip_sum = {1'b0, {1'b0, rd_r}} + (CAP_W+1)'(item.skip_count);
    if (proc) begin
      case (item.command)
        CMD_PUT: begin
          if (adv_wr != rd_r) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = wr_r;
            ram_wr.data = item.data_in;
            wr_nxt      = adv_wr;
            res.ok      = 1'b1;
          end
        end
        CMD_GET, CMD_PEEK: begin
          if (rd_r != wr_r) begin
            res.ok       = 1'b1;
            res.data_out = head_byte;
            if (item.command == CMD_GET) begin
              rd_nxt = brf_advance(rd_r, cap);
            end
          end
        end
        CMD_SKIP: begin
          if ((CAP_W+1)'(item.skip_count) <= {1'b0, lin_cur}) begin
            rd_nxt      = (skip_sum >= {1'b0, cap}) ? '0 : skip_sum[IDX_W-1:0];
            res.skipped = item.skip_count;
            res.ok      = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // a ring length write empties the fifo
    if (cfg_we) begin
      wr_nxt = '0;
      rd_nxt = '0;
    end
    used            = brf_held(wr_nxt, rd_nxt, cap);
    lin             = brf_held_lin(wr_nxt, rd_nxt, cap);
    free            = cap - CAP_W'(1) - used;
    res.used_count  = used[CNT_W-1:0];
    res.free_count  = free[CNT_W-1:0];
    res.linear_used = lin[CNT_W-1:0];
  end

  // memory reads the next head so its data is ready once rd_r holds that index
  assign ram_raddr = rd_nxt;
  assign byp_nxt   = ram_wr.en && (ram_wr.addr == rd_nxt);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      wr_r  <= '0;
      rd_r  <= '0;
      byp_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      byp_r <= byp_nxt;
    end
  end

  // forwarded byte
  always_ff @(posedge clk) begin
    byp_data_r <= ram_wr.data;
  end

  // indices stay inside the ring
  a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wr_r} < cap) && ({1'b0, rd_r} < cap))
    else $error("ring index beyond ring length");

  // an accepted put moves the write index
  a_put_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && item.command == CMD_PUT && res.ok && !cfg_we) |=> (wr_r != $past(wr_r)))
    else $error("put succeeded without moving write index");

  // a write lands where the memory is read only with forwarding armed
  a_fwd_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr.en && ram_wr.addr == ram_raddr) |=> byp_r)
    else $error("write-to-head forwarding missed");

  // occupancy never reaches the ring length
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used < cap)
    else $error("occupancy at or beyond ring length");

endmodule
